@@ rtl/tmm_pkg.sv @@
package tmm_pkg;

	// fixed axis count: roll, pitch, yaw, throttle, forward, lateral
	localparam int AXES      = 6;
	localparam int AXIS_W    = 3;
	localparam int MOTOR_W   = 3;
	localparam int ACTIVE_W  = 4;
	localparam int DATA_W    = 16;
	localparam int SET_W     = 15;

	// datapath widths
	localparam int PROD_W    = 2 * DATA_W;
	localparam int PAIR_W    = PROD_W + 1;
	localparam int SUM_W     = PROD_W + 3;
	localparam int SHIFT     = 14;
	localparam int VAL_W     = SUM_W - SHIFT;
	localparam int NEG_W     = VAL_W + 1;
	localparam int DZ_W      = NEG_W + 1;

	localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 4'd6;

	typedef enum logic [1:0] {
		CMD_LOAD_COEF = 2'd0,
		CMD_LOAD_SET  = 2'd1,
		CMD_COMPUTE   = 2'd2
	} cmd_t;

	typedef enum logic [2:0] {
		SEL_REVERSE = 3'd0,
		SEL_DZ_POS  = 3'd1,
		SEL_DZ_NEG  = 3'd2,
		SEL_LIM_POS = 3'd3,
		SEL_LIM_NEG = 3'd4
	} sel_t;

	// per-motor control that rides along the pipeline
	typedef struct packed {
		logic [MOTOR_W-1:0] motor_index;
		logic               last;
		logic               rev;
		logic [SET_W-1:0]   dzp;
		logic [SET_W-1:0]   dzn;
		logic [SET_W-1:0]   limp;
		logic [SET_W-1:0]   limn;
	} tag_t;

endpackage

@@ rtl/tmm_ifs.sv @@
// input item channel
interface tmm_item_if;
	logic        valid;
	logic        ready;
	logic [1:0]  cmd;
	logic [2:0]  motor;
	logic [2:0]  axis_column;
	logic [2:0]  setting_select;
	logic signed [15:0] load_value;
	logic signed [15:0] roll;
	logic signed [15:0] pitch;
	logic signed [15:0] yaw;
	logic signed [15:0] throttle;
	logic signed [15:0] forward;
	logic signed [15:0] lateral;

	modport source (output valid, cmd, motor, axis_column, setting_select, load_value,
		roll, pitch, yaw, throttle, forward, lateral, input ready);
	modport sink (input valid, cmd, motor, axis_column, setting_select, load_value,
		roll, pitch, yaw, throttle, forward, lateral, output ready);
endinterface

// result item channel
interface tmm_drive_if;
	logic        valid;
	logic        ready;
	logic [2:0]  motor_index;
	logic signed [15:0] drive;
	logic        last;

	modport source (output valid, motor_index, drive, last, input ready);
	modport sink (input valid, motor_index, drive, last, output ready);
endinterface

// configuration write channel
interface tmm_cfg_if;
	logic        valid;
	logic        ready;
	logic [3:0]  active_motors;

	modport source (output valid, active_motors, input ready);
	modport sink (input valid, active_motors, output ready);
endinterface

@@ rtl/tmm_lane.sv @@
// One axis lane: coefficient times demand, registered.
module tmm_lane (
	input  logic clk,
	input  logic adv,
	input  logic signed [tmm_pkg::DATA_W-1:0] coef,
	input  logic signed [tmm_pkg::DATA_W-1:0] demand,
	output logic signed [tmm_pkg::PROD_W-1:0] prod
);

	always_ff @(posedge clk) begin
		if (adv) begin
			prod <= tmm_pkg::PROD_W'(coef) * tmm_pkg::PROD_W'(demand);
		end
	end

endmodule

@@ rtl/tmm_merge.sv @@
// Merges the lane products: adder tree, shift, reversal, deadzone and clamp.
module tmm_merge (
	input  logic clk,
	input  logic arst_n,
	input  logic out_ready,
	input  logic valid_s2,
	input  tmm_pkg::tag_t tag_s2,
	input  logic signed [tmm_pkg::PROD_W-1:0] prod_s2 [tmm_pkg::AXES],
	output logic adv,
	output logic out_valid,
	output logic [tmm_pkg::MOTOR_W-1:0] out_motor_index,
	output logic signed [tmm_pkg::DATA_W-1:0] out_drive,
	output logic out_last
);

	localparam int PAIRS = tmm_pkg::AXES / 2;

	logic valid_s3, valid_s4, valid_s5, out_valid_q;
	tmm_pkg::tag_t tag_s3, tag_s4, tag_s5;
	logic signed [tmm_pkg::PAIR_W-1:0] pair_s3 [PAIRS];
	logic signed [tmm_pkg::SUM_W-1:0]  sum;
	logic signed [tmm_pkg::VAL_W-1:0]  val_s4;
	logic signed [tmm_pkg::NEG_W-1:0]  neg_s5;
	logic                              zero_s5;
	logic signed [tmm_pkg::DZ_W-1:0]   w, lo, hi, res;
	logic [tmm_pkg::MOTOR_W-1:0]       motor_q;
	logic                              last_q;
	logic signed [tmm_pkg::DATA_W-1:0] drive_q;

	// whole pipeline moves unless the output item is stalled
	assign adv = !out_valid_q || out_ready;

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3    <= 1'b0;
			valid_s4    <= 1'b0;
			valid_s5    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			valid_s3    <= valid_s2;
			valid_s4    <= valid_s3;
			valid_s5    <= valid_s4;
			out_valid_q <= valid_s5;
		end
	end

	// final sum of the pair sums
	always_comb begin
		sum = '0;
		for (int i = 0; i < PAIRS; i++) begin
			sum = sum + tmm_pkg::SUM_W'(pair_s3[i]);
		end
	end

	// deadzone away from zero, then clamp to [-limn, limp]
	always_comb begin
		if (neg_s5 < 0) begin
			w = tmm_pkg::DZ_W'(neg_s5)
				- signed'({{(tmm_pkg::DZ_W - tmm_pkg::SET_W){1'b0}}, tag_s5.dzn});
		end else begin
			w = tmm_pkg::DZ_W'(neg_s5)
				+ signed'({{(tmm_pkg::DZ_W - tmm_pkg::SET_W){1'b0}}, tag_s5.dzp});
		end
		lo = -signed'({{(tmm_pkg::DZ_W - tmm_pkg::SET_W){1'b0}}, tag_s5.limn});
		hi = signed'({{(tmm_pkg::DZ_W - tmm_pkg::SET_W){1'b0}}, tag_s5.limp});
		if (zero_s5) begin
			res = '0;
		end else if (w < lo) begin
			res = lo;
		end else if (w > hi) begin
			res = hi;
		end else begin
			res = w;
		end
	end

	// datapath stages
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < PAIRS; i++) begin
				pair_s3[i] <= tmm_pkg::PAIR_W'(prod_s2[2*i])
					+ tmm_pkg::PAIR_W'(prod_s2[2*i+1]);
			end
			tag_s3  <= tag_s2;
			// arithmetic shift floors toward minus infinity
			val_s4  <= tmm_pkg::VAL_W'(sum >>> tmm_pkg::SHIFT);
			tag_s4  <= tag_s3;
			zero_s5 <= (val_s4 == '0);
			neg_s5  <= tag_s4.rev ? -tmm_pkg::NEG_W'(val_s4) : tmm_pkg::NEG_W'(val_s4);
			tag_s5  <= tag_s4;
			motor_q <= tag_s5.motor_index;
			last_q  <= tag_s5.last;
			drive_q <= tmm_pkg::DATA_W'(res);
		end
	end

	assign out_valid       = out_valid_q;
	assign out_motor_index = motor_q;
	assign out_drive       = drive_q;
	assign out_last        = last_q;

endmodule

@@ rtl/thruster_mixing_matrix.sv @@
// Thruster mixing matrix. A load item (coefficient or motor setting) is accepted and
// writes the tables at once. A compute item starts a sequencer that issues one motor
// per cycle, while the sink does not stall, into a pipeline of six multiplier lanes
// (one per axis) and a merging stage (adder tree, shift by 14, reversal, deadzone,
// clamp); it yields min(active_motors, MOTORS) results, one per cycle when the sink
// is ready. The next item is accepted as soon as the sequencer has issued its last
// motor, so a compute holds off the input while its motors are issued, and a sink
// stall prolongs that; a load, or a compute with no active motors, holds nothing off.
// The single sequencer and the lane set it feeds limit the rate at which items are taken.
// Tables reset to zero; active_motors resets to 6 and the motor count is clamped to MOTORS.
module thruster_mixing_matrix #(
	parameter int MOTORS = 8
) (
	input  logic clk,
	input  logic arst_n,
	tmm_item_if.sink    item_in,
	tmm_drive_if.source drive_out,
	tmm_cfg_if.sink     cfg
);

	localparam int MIDX_W = (MOTORS > 1) ? $clog2(MOTORS) : 1;
	localparam int CNT_W  = $clog2(MOTORS + 1);
	localparam int AX     = tmm_pkg::AXES;
	localparam int DW     = tmm_pkg::DATA_W;
	localparam int SW     = tmm_pkg::SET_W;

	logic [tmm_pkg::ACTIVE_W-1:0] active_q;
	logic signed [DW-1:0] coef_q [MOTORS][AX];
	logic          rev_q  [MOTORS];
	logic [SW-1:0] dzp_q  [MOTORS];
	logic [SW-1:0] dzn_q  [MOTORS];
	logic [SW-1:0] limp_q [MOTORS];
	logic [SW-1:0] limn_q [MOTORS];

	logic signed [DW-1:0] demand_q  [AX];
	logic signed [DW-1:0] demand_s1 [AX];
	logic signed [DW-1:0] coef_s1   [AX];
	logic signed [tmm_pkg::PROD_W-1:0] prod_s2 [AX];
	tmm_pkg::tag_t tag_s1, tag_s2;
	logic valid_s1, valid_s2;

	logic              busy_q;
	logic [MIDX_W-1:0] k_q;
	logic [CNT_W-1:0]  n_q, n_sel;
	logic              item_acc, ld_coef, ld_set, compute, motor_ok, axis_ok;
	logic              adv, issue, last_k;
	logic [MIDX_W-1:0] midx;

	// configuration register
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= tmm_pkg::ACTIVE_RESET;
		end else if (cfg.valid && cfg.ready) begin
			active_q <= cfg.active_motors;
		end
	end

	// command decode
	assign item_acc = item_in.valid && item_in.ready;
	assign motor_ok = 32'(item_in.motor) < MOTORS;
	assign axis_ok  = 32'(item_in.axis_column) < AX;
	assign midx     = MIDX_W'(item_in.motor);
	always_comb begin
		ld_coef = 1'b0;
		ld_set  = 1'b0;
		compute = 1'b0;
		unique case (item_in.cmd)
			tmm_pkg::CMD_LOAD_COEF: ld_coef = item_acc && motor_ok && axis_ok;
			tmm_pkg::CMD_LOAD_SET:  ld_set  = item_acc && motor_ok;
			tmm_pkg::CMD_COMPUTE:   compute = item_acc;
			default: ;
		endcase
	end

	// coefficient and setting tables
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int m = 0; m < MOTORS; m++) begin
				for (int a = 0; a < AX; a++) begin
					coef_q[m][a] <= '0;
				end
				rev_q[m]  <= 1'b0;
				dzp_q[m]  <= '0;
				dzn_q[m]  <= '0;
				limp_q[m] <= '0;
				limn_q[m] <= '0;
			end
		end else begin
			if (ld_coef) begin
				coef_q[midx][item_in.axis_column] <= item_in.load_value;
			end
			if (ld_set) begin
				case (item_in.setting_select)
					tmm_pkg::SEL_REVERSE: rev_q[midx]  <= item_in.load_value[0];
					tmm_pkg::SEL_DZ_POS:  dzp_q[midx]  <= item_in.load_value[SW-1:0];
					tmm_pkg::SEL_DZ_NEG:  dzn_q[midx]  <= item_in.load_value[SW-1:0];
					tmm_pkg::SEL_LIM_POS: limp_q[midx] <= item_in.load_value[SW-1:0];
					tmm_pkg::SEL_LIM_NEG: limn_q[midx] <= item_in.load_value[SW-1:0];
					default: ;
				endcase
			end
		end
	end

	// motor count, saturated to MOTORS
	assign n_sel = (32'(active_q) > MOTORS) ? CNT_W'(MOTORS) : CNT_W'(active_q);

	// motor sequencer
	assign issue   = busy_q && adv;
	assign last_k  = (CNT_W'(k_q) + CNT_W'(1)) == n_q;
	assign item_in.ready = !busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			k_q    <= '0;
			n_q    <= '0;
		end else if (compute) begin
			busy_q <= (n_sel != '0);
			k_q    <= '0;
			n_q    <= n_sel;
		end else if (issue) begin
			k_q <= k_q + 1'b1;
			if (last_k) begin
				busy_q <= 1'b0;
			end
		end
	end

	// demand latch
	always_ff @(posedge clk) begin
		if (compute) begin
			demand_q[0] <= item_in.roll;
			demand_q[1] <= item_in.pitch;
			demand_q[2] <= item_in.yaw;
			demand_q[3] <= item_in.throttle;
			demand_q[4] <= item_in.forward;
			demand_q[5] <= item_in.lateral;
		end
	end

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= issue;
			valid_s2 <= valid_s1;
		end
	end

	// stage 1 captures the row so later loads cannot disturb it
	always_ff @(posedge clk) begin
		if (adv) begin
			if (issue) begin
				for (int a = 0; a < AX; a++) begin
					coef_s1[a]   <= coef_q[k_q][a];
					demand_s1[a] <= demand_q[a];
				end
				tag_s1.motor_index <= tmm_pkg::MOTOR_W'(k_q);
				tag_s1.last        <= last_k;
				tag_s1.rev         <= rev_q[k_q];
				tag_s1.dzp         <= dzp_q[k_q];
				tag_s1.dzn         <= dzn_q[k_q];
				tag_s1.limp        <= limp_q[k_q];
				tag_s1.limn        <= limn_q[k_q];
			end
			tag_s2 <= tag_s1;
		end
	end

	// axis lanes
	for (genvar a = 0; a < AX; a++) begin : g_lane
		tmm_lane u_lane (
			.clk    (clk),
			.adv    (adv),
			.coef   (coef_s1[a]),
			.demand (demand_s1[a]),
			.prod   (prod_s2[a])
		);
	end

	// merge and output stage
	tmm_merge u_merge (
		.clk             (clk),
		.arst_n          (arst_n),
		.out_ready       (drive_out.ready),
		.valid_s2        (valid_s2),
		.tag_s2          (tag_s2),
		.prod_s2         (prod_s2),
		.adv             (adv),
		.out_valid       (drive_out.valid),
		.out_motor_index (drive_out.motor_index),
		.out_drive       (drive_out.drive),
		.out_last        (drive_out.last)
	);

`ifndef SYNTHESIS
	// no new item while motors are still being issued
	a_ready_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !item_in.ready)
		else $error("item accepted while sequencer busy");

	// a compute with no active motors starts nothing
	a_zero_count: assert property (@(posedge clk) disable iff (!arst_n)
		(compute && n_sel == '0) |=> !busy_q)
		else $error("sequencer started with zero motors");

	// issuing the last motor ends the sequence
	a_seq_end: assert property (@(posedge clk) disable iff (!arst_n)
		(issue && last_k && !compute) |=> !busy_q)
		else $error("sequencer ran past last motor");

	// clamped drive never reaches the most negative code
	a_drive_range: assert property (@(posedge clk) disable iff (!arst_n)
		drive_out.valid |-> drive_out.drive != 16'sh8000)
		else $error("drive out of range");
`endif

endmodule
